@@ design/atvc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atvc_pkg
// Shared constants and types for the averaged-threshold valve control block.
// ----------------------------------------------------------------------------
package atvc_pkg;

	// Default sizes of the averaging window, button history and sample word.
	localparam int AVG_WINDOW_DEF    = 60;
	localparam int BUTTON_WINDOW_DEF = 20;
	localparam int SAMPLE_BITS_DEF   = 12;

	// The threshold register is a 12-bit ADC code with a fixed reset value.
	localparam int              THRESH_W     = 12;
	localparam logic [11:0]     THRESH_RESET = 12'd2482;

	// Status of one word leaving the sample window.
	typedef struct packed {
		logic subtract_old;  // window was full: oldest sample leaves the sum
		logic full;          // window is full after this word: average valid
	} win_status_t;

	// Commands from the valve controller for one word.
	typedef struct packed {
		logic open_pulse;
		logic close_pulse;
		logic valve_is_open;
		logic manual_mode;
	} valve_out_t;

endpackage : atvc_pkg
`default_nettype wire

@@ design/averaged_threshold_valve_control_top.sv @@
`default_nettype none
// Throughput: one word per cycle while out_stall does not hold the output;
// the four-stage pipeline (window read, running sum, reciprocal multiply,
// valve decision) has no shared unit.
// Reset: pipeline empty, window empty, running sum 0, valve closed, automatic
// mode, button history all high, threshold 2482.
// ----------------------------------------------------------------------------
// averaged_threshold_valve_control_top
// Sliding-window throttle average with threshold valve control and a
// debounced manual toggle button.
// ----------------------------------------------------------------------------
module averaged_threshold_valve_control_top
	import atvc_pkg::*;
#(
	parameter int AVG_WINDOW    = AVG_WINDOW_DEF,
	parameter int BUTTON_WINDOW = BUTTON_WINDOW_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration.
	input  logic                   cfg_wr_en,
	input  logic [THRESH_W-1:0]    cfg_wr_data,
	// Input channel.
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] throttle_sample,
	input  logic                   button_level,
	// Output channel.
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   open_pulse,
	output logic                   close_pulse,
	output logic                   valve_is_open,
	output logic                   manual_mode,
	output logic [SAMPLE_BITS-1:0] throttle_average
);

	localparam int LOG_W   = $clog2(AVG_WINDOW);
	localparam int SUM_W   = SAMPLE_BITS + LOG_W;
	localparam int SHIFT_K = SUM_W + LOG_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int CMP_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
	// Rounded-up reciprocal of the window size; exact floor for every sum.
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT_K) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	logic [THRESH_W-1:0]    open_threshold_q;

	logic                   v_s1, v_s2, v_s3, out_valid_q;
	logic                   ld_s1, ld_s2, ld_s3, ld_out;
	logic                   mv_s1, mv_s2, mv_s3;
	logic                   accept;

	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   level_s1, level_s2, level_s3;
	logic                   full_s2, full_s3;
	logic [SAMPLE_BITS-1:0] old_sample;
	win_status_t            win_status;
	logic [SUM_W-1:0]       running_sum_q;
	logic [SUM_W-1:0]       sum_next;
	logic [PROD_W-1:0]      prod_s3;
	logic [SAMPLE_BITS-1:0] avg;
	logic                   above;
	valve_out_t             cmd;

	logic                   open_pulse_q, close_pulse_q, valve_is_open_q, manual_mode_q;
	logic [SAMPLE_BITS-1:0] throttle_average_q;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_threshold_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			open_threshold_q <= cfg_wr_data;
		end
	end

	// Pipeline flow: a stage loads when empty or when its word moves on.
	always_comb begin
		ld_out = !out_valid_q || !out_stall;
		mv_s3  = v_s3 && ld_out;
		ld_s3  = !v_s3 || ld_out;
		mv_s2  = v_s2 && ld_s3;
		ld_s2  = !v_s2 || ld_s3;
		mv_s1  = v_s1 && ld_s2;
		ld_s1  = !v_s1 || ld_s2;
		accept = in_valid && ld_s1;
	end

	assign in_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= in_valid;
			end
			if (ld_s2) begin
				v_s2 <= mv_s1;
			end
			if (ld_s3) begin
				v_s3 <= mv_s2;
			end
			if (ld_out) begin
				out_valid_q <= mv_s3;
			end
		end
	end

	// Stage 1: sample store; old sample and window status come out registered.
	atvc_window #(
		.AVG_WINDOW  (AVG_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (throttle_sample),
		.rd_data (old_sample),
		.status  (win_status)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= throttle_sample;
			level_s1  <= button_level;
		end
	end

	// Stage 2: running sum update; the sum register belongs to the word in stage 2.
	always_comb begin
		sum_next = running_sum_q + SUM_W'(sample_s1);
		if (win_status.subtract_old) begin
			sum_next = sum_next - SUM_W'(old_sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (mv_s1) begin
			running_sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			level_s2 <= level_s1;
			full_s2  <= win_status.full;
		end
	end

	// Stage 3: divide by the window size as a multiply by its reciprocal.
	always_ff @(posedge clk) begin
		if (mv_s2) begin
			prod_s3  <= PROD_W'(running_sum_q) * PROD_W'(RECIP);
			level_s3 <= level_s2;
			full_s3  <= full_s2;
		end
	end

	// Average is zero until the window has filled once.
	always_comb begin
		avg   = full_s3 ? prod_s3[SHIFT_K +: SAMPLE_BITS] : '0;
		above = (CMP_W'(avg) > CMP_W'(open_threshold_q));
	end

	atvc_valve #(
		.BUTTON_WINDOW (BUTTON_WINDOW)
	) u_valve (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (mv_s3),
		.level  (level_s3),
		.above  (above),
		.cmd    (cmd)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (mv_s3) begin
			open_pulse_q       <= cmd.open_pulse;
			close_pulse_q      <= cmd.close_pulse;
			valve_is_open_q    <= cmd.valve_is_open;
			manual_mode_q      <= cmd.manual_mode;
			throttle_average_q <= avg;
		end
	end

	assign out_valid        = out_valid_q;
	assign open_pulse       = open_pulse_q;
	assign close_pulse      = close_pulse_q;
	assign valve_is_open    = valve_is_open_q;
	assign manual_mode      = manual_mode_q;
	assign throttle_average = throttle_average_q;

endmodule : averaged_threshold_valve_control_top
`default_nettype wire

@@ design/atvc_window.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atvc_window
// Circular sample store for the sliding average. Each accepted word is written
// over the oldest slot; the old contents are read out in the same cycle.
// ----------------------------------------------------------------------------
module atvc_window
	import atvc_pkg::*;
#(
	parameter int AVG_WINDOW  = AVG_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [SAMPLE_BITS-1:0] wr_data,
	output logic [SAMPLE_BITS-1:0] rd_data,
	output win_status_t            status
);

	localparam int PTR_W  = $clog2(AVG_WINDOW);
	localparam int FILL_W = $clog2(AVG_WINDOW + 1);

	logic [SAMPLE_BITS-1:0] mem [AVG_WINDOW];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [FILL_W-1:0]      fill_q;
	win_status_t            status_q;
	logic                   is_full;

	assign is_full = (fill_q == FILL_W'(AVG_WINDOW));

	// Read-first memory: the oldest sample comes out as the new one goes in.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_data_q     <= mem[wr_ptr_q];
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Write pointer, fill count and per-word status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
			status_q <= '0;
		end else if (wr_en) begin
			if (wr_ptr_q == PTR_W'(AVG_WINDOW - 1)) begin
				wr_ptr_q <= '0;
			end else begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (!is_full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			status_q.subtract_old <= is_full;
			status_q.full         <= (fill_q >= FILL_W'(AVG_WINDOW - 1));
		end
	end

	assign rd_data = rd_data_q;
	assign status  = status_q;

endmodule : atvc_window
`default_nettype wire

@@ design/atvc_valve.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atvc_valve
// Button debounce with a single toggle per press, plus the automatic
// open/close rule on the window average.
// ----------------------------------------------------------------------------
module atvc_valve
	import atvc_pkg::*;
#(
	parameter int BUTTON_WINDOW = BUTTON_WINDOW_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       level,
	input  logic       above,
	output valve_out_t cmd
);

	logic [BUTTON_WINDOW-1:0] hist_q;
	logic [BUTTON_WINDOW-1:0] hist_next;
	logic                     was_low_q;
	logic                     valve_q;
	logic                     manual_q;
	logic                     now_low;
	valve_out_t               nxt;

	// Next state for one word: button toggle first, then the automatic rule.
	always_comb begin
		hist_next = {hist_q[BUTTON_WINDOW-2:0], level};
		now_low   = (hist_next == '0);
		nxt.open_pulse    = 1'b0;
		nxt.close_pulse   = 1'b0;
		nxt.valve_is_open = valve_q;
		nxt.manual_mode   = manual_q;
		if (now_low && !was_low_q) begin
			if (valve_q) begin
				nxt.close_pulse   = 1'b1;
				nxt.valve_is_open = 1'b0;
				nxt.manual_mode   = 1'b0;
			end else begin
				nxt.open_pulse    = 1'b1;
				nxt.valve_is_open = 1'b1;
				nxt.manual_mode   = 1'b1;
			end
		end
		if (!nxt.manual_mode) begin
			if (above && !nxt.valve_is_open) begin
				nxt.open_pulse    = 1'b1;
				nxt.valve_is_open = 1'b1;
			end else if (!above && nxt.valve_is_open) begin
				nxt.close_pulse   = 1'b1;
				nxt.valve_is_open = 1'b0;
			end
		end
	end

	// Controller state advances once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= '1;
			was_low_q <= 1'b0;
			valve_q   <= 1'b0;
			manual_q  <= 1'b0;
		end else if (step) begin
			hist_q    <= hist_next;
			was_low_q <= now_low;
			valve_q   <= nxt.valve_is_open;
			manual_q  <= nxt.manual_mode;
		end
	end

	assign cmd = nxt;

endmodule : atvc_valve
`default_nettype wire
